@@ rtl/core/cmsp_pkg.sv @@
// Package for the CoAP message stream parser.
// Parse phases, byte classes, status codes, parser state and result types.
// No dependencies.
package cmsp_pkg;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_TOKEN,
        PH_OPTHEAD,
        PH_OPTEXT,
        PH_OPTVAL,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

    localparam logic [2:0] CLS_HEADER   = 3'd0;
    localparam logic [2:0] CLS_TOKEN    = 3'd1;
    localparam logic [2:0] CLS_OPT_HEAD = 3'd2;
    localparam logic [2:0] CLS_OPT_EXT  = 3'd3;
    localparam logic [2:0] CLS_OPT_VAL  = 3'd4;
    localparam logic [2:0] CLS_MARKER   = 3'd5;
    localparam logic [2:0] CLS_PAYLOAD  = 3'd6;
    localparam logic [2:0] CLS_IGNORED  = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_VERSION   = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    localparam logic [1:0] MT_NON = 2'd1;
    localparam logic [1:0] MT_RST = 2'd3;

    localparam logic [1:0] COAP_VERSION  = 2'd1;
    localparam logic [3:0] MAX_TOKEN_LEN = 4'd8;
    localparam logic [3:0] NIB_EXT8      = 4'd13;
    localparam logic [3:0] NIB_EXT16     = 4'd14;
    localparam logic [3:0] NIB_RESERVED  = 4'd15;
    localparam logic [7:0] PAYLOAD_MARK  = 8'hFF;
    localparam logic [16:0] EXT8_BASE    = 17'd13;
    localparam logic [16:0] EXT16_BASE   = 17'd269;

    typedef struct packed {
        phase_t      phase;
        logic [16:0] phase_count;
        logic [1:0]  hdr_type;
        logic [3:0]  hdr_token_len;
        logic [2:0]  hdr_class;
        logic [4:0]  hdr_detail;
        logic [15:0] hdr_msg_id;
        logic [16:0] delta_acc;
        logic [16:0] length_acc;
        logic [15:0] prev_option_number;
        logic        saw_option;
        logic        saw_payload;
        logic [1:0]  error_code;
        logic [1:0]  dlt_left;
        logic        dlt_wide;
        logic [1:0]  len_left;
        logic        len_wide;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        phase: PH_HDR,
        phase_count: 17'd0,
        hdr_type: 2'd0,
        hdr_token_len: 4'd0,
        hdr_class: 3'd0,
        hdr_detail: 5'd0,
        hdr_msg_id: 16'd0,
        delta_acc: 17'd0,
        length_acc: 17'd0,
        prev_option_number: 16'd0,
        saw_option: 1'b0,
        saw_payload: 1'b0,
        error_code: 2'd0,
        dlt_left: 2'd0,
        dlt_wide: 1'b0,
        len_left: 2'd0,
        len_wide: 1'b0
    };

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [7:0]  data_out;
        logic [15:0] option_number;
        logic [16:0] option_length;
        logic        done_res;
        logic [1:0]  status;
        logic [1:0]  msg_type;
        logic [3:0]  token_length;
        logic [2:0]  msg_class;
        logic [4:0]  msg_detail;
        logic [15:0] message_id;
    } result_t;

endpackage

@@ rtl/core/cmsp_in_stage.sv @@
// Input register stage of the CoAP message stream parser.
// Holds one accepted item until the decode stage takes it. Uses nothing else.
module cmsp_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data,
    input  logic       last,
    input  logic       take,
    output logic       valid_q,
    output logic [7:0] data_q,
    output logic       last_q
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data;
            last_reg <= last;
        end
    end

    assign valid_q = valid_reg;
    assign data_q  = data_reg;
    assign last_q  = last_reg;

endmodule

@@ rtl/core/cmsp_decode.sv @@
// Per-byte decode of the CoAP message stream parser.
// Next parser state and the result for one byte, from the current state.
// Depends on cmsp_pkg.
module cmsp_decode
    import cmsp_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   data,
    input  logic         last,
    output parse_state_t nxt,
    output result_t      res
);

    parse_state_t upd;
    logic [2:0]   cls;
    logic         show;
    logic [1:0]   status;
    logic [3:0]   dn;
    logic [3:0]   ln;
    logic [16:0]  head_sum;
    logic [16:0] ext_delta;
    logic [17:0] ext_sum;
    logic [16:0] ext_len;
    logic        class_ok;

    assign dn        = data[7:4];
    assign ln        = data[3:0];
    assign head_sum  = {1'b0, cur.prev_option_number} + {13'd0, dn};
    assign ext_delta = {1'b0, cur.delta_acc[7:0], data}
                       + (cur.dlt_wide ? EXT16_BASE : EXT8_BASE);
    assign ext_sum   = {2'b00, cur.prev_option_number} + {1'b0, ext_delta};
    assign ext_len   = {1'b0, cur.length_acc[7:0], data}
                       + (cur.len_wide ? EXT16_BASE : EXT8_BASE);
    assign class_ok  = (data[7:5] == 3'd0) || (data[7:5] == 3'd2)
                       || (data[7:5] == 3'd4) || (data[7:5] == 3'd5);

    always_comb
    begin
        upd  = cur;
        cls  = CLS_IGNORED;
        show = 1'b0;
        case (cur.phase)
            PH_HDR:
            begin
                cls = CLS_HEADER;
                case (cur.phase_count[1:0])
                    2'd0:
                    begin
                        upd.hdr_type      = data[5:4];
                        upd.hdr_token_len = data[3:0];
                        if (data[7:6] != COAP_VERSION)
                        begin
                            upd.error_code = ST_VERSION;
                        end
                        else if (data[3:0] > MAX_TOKEN_LEN)
                        begin
                            upd.error_code = ST_MALFORMED;
                        end
                    end
                    2'd1:
                    begin
                        upd.hdr_class  = data[7:5];
                        upd.hdr_detail = data[4:0];
                        if (cur.error_code == ST_OK && !class_ok)
                        begin
                            upd.error_code = ST_MALFORMED;
                        end
                    end
                    2'd2:
                    begin
                        upd.hdr_msg_id = {data, 8'h00};
                    end
                    default:
                    begin
                        upd.hdr_msg_id = {cur.hdr_msg_id[15:8], data};
                    end
                endcase
                if (cur.phase_count[1:0] != 2'd3)
                begin
                    upd.phase_count = cur.phase_count + 17'd1;
                end
                else if (upd.error_code != ST_OK)
                begin
                    upd.phase = PH_ERROR;
                end
                else if (upd.hdr_token_len != 4'd0)
                begin
                    upd.phase       = PH_TOKEN;
                    upd.phase_count = {13'd0, upd.hdr_token_len};
                end
                else
                begin
                    upd.phase = PH_OPTHEAD;
                end
            end
            PH_TOKEN:
            begin
                cls = CLS_TOKEN;
                if (cur.phase_count != 17'd0)
                begin
                    upd.phase_count = cur.phase_count - 17'd1;
                end
                if (upd.phase_count == 17'd0)
                begin
                    upd.phase = PH_OPTHEAD;
                end
            end
            PH_OPTHEAD:
            begin
                if (data == PAYLOAD_MARK)
                begin
                    cls       = CLS_MARKER;
                    upd.phase = PH_PAYLOAD;
                end
                else
                begin
                    cls            = CLS_OPT_HEAD;
                    show           = 1'b1;
                    upd.length_acc = 17'd0;
                    if (dn == NIB_RESERVED || ln == NIB_RESERVED)
                    begin
                        upd.error_code = ST_MALFORMED;
                        upd.phase      = PH_ERROR;
                    end
                    else
                    begin
                        upd.saw_option = 1'b1;
                        upd.dlt_wide   = (dn == NIB_EXT16);
                        upd.dlt_left   = (dn < NIB_EXT8) ? 2'd0
                                         : ((dn == NIB_EXT8) ? 2'd1 : 2'd2);
                        upd.len_wide   = (ln == NIB_EXT16);
                        upd.len_left   = (ln < NIB_EXT8) ? 2'd0
                                         : ((ln == NIB_EXT8) ? 2'd1 : 2'd2);
                        upd.length_acc = (ln < NIB_EXT8) ? {13'd0, ln} : 17'd0;
                        upd.delta_acc  = (dn < NIB_EXT8) ? {13'd0, dn} : 17'd0;
                        if (dn < NIB_EXT8)
                        begin
                            if (head_sum[16])
                            begin
                                upd.error_code = ST_MALFORMED;
                                upd.phase      = PH_ERROR;
                            end
                            else
                            begin
                                upd.prev_option_number = head_sum[15:0];
                            end
                        end
                        if (upd.phase != PH_ERROR)
                        begin
                            if (dn < NIB_EXT8 && ln < NIB_EXT8)
                            begin
                                if (ln == 4'd0)
                                begin
                                    upd.phase = PH_OPTHEAD;
                                end
                                else
                                begin
                                    upd.phase       = PH_OPTVAL;
                                    upd.phase_count = {13'd0, ln};
                                end
                            end
                            else
                            begin
                                upd.phase = PH_OPTEXT;
                            end
                        end
                    end
                end
            end
            PH_OPTEXT:
            begin
                cls  = CLS_OPT_EXT;
                show = 1'b1;
                if (cur.dlt_left != 2'd0)
                begin
                    upd.delta_acc = {1'b0, cur.delta_acc[7:0], data};
                    upd.dlt_left  = cur.dlt_left - 2'd1;
                    if (cur.dlt_left == 2'd1)
                    begin
                        upd.delta_acc = ext_delta;
                        if (ext_sum[17:16] != 2'b00)
                        begin
                            upd.error_code = ST_MALFORMED;
                            upd.phase      = PH_ERROR;
                        end
                        else
                        begin
                            upd.prev_option_number = ext_sum[15:0];
                        end
                    end
                end
                else if (cur.len_left != 2'd0)
                begin
                    upd.length_acc = {1'b0, cur.length_acc[7:0], data};
                    upd.len_left   = cur.len_left - 2'd1;
                    if (cur.len_left == 2'd1)
                    begin
                        upd.length_acc = ext_len;
                    end
                end
                if (upd.phase != PH_ERROR && upd.dlt_left == 2'd0
                    && upd.len_left == 2'd0)
                begin
                    if (upd.length_acc == 17'd0)
                    begin
                        upd.phase = PH_OPTHEAD;
                    end
                    else
                    begin
                        upd.phase       = PH_OPTVAL;
                        upd.phase_count = upd.length_acc;
                    end
                end
            end
            PH_OPTVAL:
            begin
                cls  = CLS_OPT_VAL;
                show = 1'b1;
                if (cur.phase_count != 17'd0)
                begin
                    upd.phase_count = cur.phase_count - 17'd1;
                end
                if (upd.phase_count == 17'd0)
                begin
                    upd.phase = PH_OPTHEAD;
                end
            end
            PH_PAYLOAD:
            begin
                cls             = CLS_PAYLOAD;
                upd.saw_payload = 1'b1;
            end
            default:
            begin
                cls       = CLS_IGNORED;
                upd.phase = PH_ERROR;
            end
        endcase
    end

    // Final status, precedence: short header, latched error, early end, empty/reset rules
    always_comb
    begin
        status = ST_OK;
        if (last)
        begin
            if (upd.phase == PH_HDR)
            begin
                status = ST_MALFORMED;
            end
            else if (upd.error_code != ST_OK)
            begin
                status = upd.error_code;
            end
            else if (!(upd.phase == PH_OPTHEAD
                       || (upd.phase == PH_PAYLOAD && upd.saw_payload)))
            begin
                status = ST_MALFORMED;
            end
            else if (upd.hdr_class == 3'd0 && upd.hdr_detail == 5'd0)
            begin
                status = (upd.hdr_type == MT_NON || upd.hdr_token_len != 4'd0
                          || upd.saw_option || upd.saw_payload) ? ST_MALFORMED : ST_OK;
            end
            else
            begin
                status = (upd.hdr_type == MT_RST) ? ST_MALFORMED : ST_OK;
            end
        end
    end

    always_comb
    begin
        res.byte_class    = cls;
        res.data_out      = data;
        res.option_number = show ? upd.prev_option_number : 16'd0;
        res.option_length = show ? upd.length_acc : 17'd0;
        res.done_res      = last;
        res.status        = status;
        res.msg_type      = upd.hdr_type;
        res.token_length  = upd.hdr_token_len;
        res.msg_class     = upd.hdr_class;
        res.msg_detail    = upd.hdr_detail;
        res.message_id    = upd.hdr_msg_id;
    end

    assign nxt = last ? PARSE_RESET : upd;

endmodule

@@ rtl/core/coap_message_stream_parser_top.sv @@
// CoAP message stream parser, top level.
// Input register, per-byte decode, parser state and result register.
// Depends on cmsp_pkg, cmsp_in_stage and cmsp_decode.
//
// Takes one datagram byte per item, with last on the final byte, and returns one
// labelled result per byte. One item is accepted every clock cycle when the output
// side keeps taking results; a result is presented once its byte has passed the input
// register and been decoded into the result register, which waits while a result
// is held. The parser state is updated together with the result register. The
// result for the last byte carries the final status, and the parser then returns
// to its reset state for the next datagram.
module coap_message_stream_parser_top
    import cmsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  byte_class,
    output logic [7:0]  data_out,
    output logic [15:0] option_number,
    output logic [16:0] option_length,
    output logic        done_res,
    output logic [1:0]  status,
    output logic [1:0]  msg_type,
    output logic [3:0]  token_length,
    output logic [2:0]  msg_class,
    output logic [4:0]  msg_detail,
    output logic [15:0] message_id
);

    logic         s1_valid;
    logic [7:0]   s1_data;
    logic         s1_last;
    logic         advance;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      res_next;
    result_t      res_reg;
    logic         out_valid_reg;

    assign advance = s1_valid && (!out_valid_reg || out_ready);

    cmsp_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .data     (data),
        .last     (last),
        .take     (advance),
        .valid_q  (s1_valid),
        .data_q   (s1_data),
        .last_q   (s1_last)
    );

    cmsp_decode u_decode
    (
        .cur  (state_reg),
        .data (s1_data),
        .last (s1_last),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PARSE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_class    = res_reg.byte_class;
    assign data_out      = res_reg.data_out;
    assign option_number = res_reg.option_number;
    assign option_length = res_reg.option_length;
    assign done_res      = res_reg.done_res;
    assign status        = res_reg.status;
    assign msg_type      = res_reg.msg_type;
    assign token_length  = res_reg.token_length;
    assign msg_class     = res_reg.msg_class;
    assign msg_detail    = res_reg.msg_detail;
    assign message_id    = res_reg.message_id;

    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_last |=> state_reg.phase == PH_HDR && state_reg.phase_count == 17'd0)
        else $error("parser state not cleared after last byte");

    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> status == ST_OK)
        else $error("status set on a result that is not the last");

    a_no_option_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_class == CLS_HEADER || byte_class == CLS_TOKEN
                      || byte_class == CLS_PAYLOAD)
        |-> option_number == 16'd0 && option_length == 17'd0)
        else $error("option fields set outside options");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid && out_valid && !out_ready)
        else $error("input stalled without a full pipeline");

endmodule

@@ tb/sv/coap_message_stream_parser_top_tb.sv @@
// Testbench for coap_message_stream_parser_top: byte stream stimulus, a scoreboard that
// labels every byte and predicts the final status, and random idling on both sides.
// Depends on cmsp_pkg and the parser RTL.
`timescale 1ns / 100ps

module coap_message_stream_parser_top_tb;
    import cmsp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned ITEM_TARGET = 1400;
    localparam int unsigned CALM_FROM   = 1150;

    // code classes accepted by the header check
    localparam logic [2:0] CC_REQ        = 3'd0;
    localparam logic [2:0] CC_OK         = 3'd2;
    localparam logic [2:0] CC_CLIENT_ERR = 3'd4;
    localparam logic [2:0] CC_SERVER_ERR = 3'd5;

    localparam logic [1:0] MT_CON = 2'd0;
    localparam logic [1:0] MT_ACK = 2'd2;

    class coap_label_scoreboard;
        result_t     labels_due[$];
        int unsigned errors;
        int unsigned checked;

        phase_t      ph;
        logic [16:0] cnt;
        logic [1:0]  m_type;
        logic [3:0]  tok_len;
        logic [2:0]  code_cls;
        logic [4:0]  code_det;
        logic [15:0] msg_id;
        logic [16:0] dlt_acc;
        logic [16:0] len_acc;
        logic [15:0] last_opt_num;
        logic        saw_opt;
        logic        saw_pay;
        logic [1:0]  err;
        logic [1:0]  dlt_left;
        logic        dlt_wide;
        logic [1:0]  len_left;
        logic        len_wide;

        function new();
            errors  = 0;
            checked = 0;
            clear_state();
        endfunction

        function void clear_state();
            ph           = PH_HDR;
            cnt          = '0;
            m_type       = '0;
            tok_len      = '0;
            code_cls     = '0;
            code_det     = '0;
            msg_id       = '0;
            dlt_acc      = '0;
            len_acc      = '0;
            last_opt_num = '0;
            saw_opt      = 1'b0;
            saw_pay      = 1'b0;
            err          = ST_OK;
            dlt_left     = '0;
            dlt_wide     = 1'b0;
            len_left     = '0;
            len_wide     = 1'b0;
        endfunction

        function void malformed();
            err = ST_MALFORMED;
            ph  = PH_ERROR;
        endfunction

        function void add_delta();
            logic [17:0] sum;
            sum = {2'b00, last_opt_num} + {1'b0, dlt_acc};
            if (sum > 18'd65535)
                malformed();
            else
                last_opt_num = sum[15:0];
        endfunction

        function void start_value();
            if (len_acc == '0)
                ph = PH_OPTHEAD;
            else
            begin
                ph  = PH_OPTVAL;
                cnt = len_acc;
            end
        endfunction

        function int unsigned pending();
            return labels_due.size();
        endfunction

        // label one accepted byte and queue the result it should produce
        function void label_byte(logic [7:0] b, logic fin);
            result_t    r;
            logic [3:0] dn;
            logic [3:0] ln;
            logic [1:0] st;
            logic       show;
            r = '0;
            show = 1'b0;
            st = ST_OK;
            r.byte_class = CLS_IGNORED;
            case (ph)
                PH_HDR:
                begin
                    r.byte_class = CLS_HEADER;
                    case (cnt)
                        17'd0:
                        begin
                            m_type  = b[5:4];
                            tok_len = b[3:0];
                            if (b[7:6] != COAP_VERSION)
                                err = ST_VERSION;
                            else if (tok_len > MAX_TOKEN_LEN)
                                err = ST_MALFORMED;
                        end
                        17'd1:
                        begin
                            code_cls = b[7:5];
                            code_det = b[4:0];
                            if (err == ST_OK && code_cls != CC_REQ && code_cls != CC_OK &&
                                code_cls != CC_CLIENT_ERR && code_cls != CC_SERVER_ERR)
                                err = ST_MALFORMED;
                        end
                        17'd2: msg_id = {b, 8'h00};
                        default: msg_id[7:0] = b;
                    endcase
                    if (cnt < 17'd3)
                        cnt = cnt + 17'd1;
                    else if (err != ST_OK)
                        ph = PH_ERROR;
                    else if (tok_len != 4'd0)
                    begin
                        ph  = PH_TOKEN;
                        cnt = {13'd0, tok_len};
                    end
                    else
                        ph = PH_OPTHEAD;
                end
                PH_TOKEN:
                begin
                    r.byte_class = CLS_TOKEN;
                    if (cnt != '0)
                        cnt = cnt - 17'd1;
                    if (cnt == '0)
                        ph = PH_OPTHEAD;
                end
                PH_OPTHEAD:
                begin
                    if (b == PAYLOAD_MARK)
                    begin
                        r.byte_class = CLS_MARKER;
                        ph = PH_PAYLOAD;
                    end
                    else
                    begin
                        r.byte_class = CLS_OPT_HEAD;
                        show = 1'b1;
                        dn = b[7:4];
                        ln = b[3:0];
                        len_acc = '0;
                        if (dn == NIB_RESERVED || ln == NIB_RESERVED)
                            malformed();
                        else
                        begin
                            saw_opt  = 1'b1;
                            dlt_wide = (dn == NIB_EXT16);
                            dlt_left = (dn < NIB_EXT8) ? 2'd0 : (dn == NIB_EXT8 ? 2'd1 : 2'd2);
                            len_wide = (ln == NIB_EXT16);
                            len_left = (ln < NIB_EXT8) ? 2'd0 : (ln == NIB_EXT8 ? 2'd1 : 2'd2);
                            len_acc  = (ln < NIB_EXT8) ? {13'd0, ln} : 17'd0;
                            dlt_acc  = (dn < NIB_EXT8) ? {13'd0, dn} : 17'd0;
                            if (dlt_left == 2'd0)
                                add_delta();
                            if (ph != PH_ERROR)
                            begin
                                if (dlt_left == 2'd0 && len_left == 2'd0)
                                    start_value();
                                else
                                    ph = PH_OPTEXT;
                            end
                        end
                    end
                end
                PH_OPTEXT:
                begin
                    r.byte_class = CLS_OPT_EXT;
                    show = 1'b1;
                    if (dlt_left != 2'd0)
                    begin
                        dlt_acc  = {1'b0, dlt_acc[7:0], b};
                        dlt_left = dlt_left - 2'd1;
                        if (dlt_left == 2'd0)
                        begin
                            dlt_acc = dlt_acc + (dlt_wide ? EXT16_BASE : EXT8_BASE);
                            add_delta();
                        end
                    end
                    else if (len_left != 2'd0)
                    begin
                        len_acc  = {1'b0, len_acc[7:0], b};
                        len_left = len_left - 2'd1;
                        if (len_left == 2'd0)
                            len_acc = len_acc + (len_wide ? EXT16_BASE : EXT8_BASE);
                    end
                    if (ph != PH_ERROR && dlt_left == 2'd0 && len_left == 2'd0)
                        start_value();
                end
                PH_OPTVAL:
                begin
                    r.byte_class = CLS_OPT_VAL;
                    show = 1'b1;
                    if (cnt != '0)
                        cnt = cnt - 17'd1;
                    if (cnt == '0)
                        ph = PH_OPTHEAD;
                end
                PH_PAYLOAD:
                begin
                    r.byte_class = CLS_PAYLOAD;
                    saw_pay = 1'b1;
                end
                default:
                begin
                    r.byte_class = CLS_IGNORED;
                    ph = PH_ERROR;
                end
            endcase

            if (fin)
            begin
                if (ph == PH_HDR)
                    st = ST_MALFORMED;
                else if (err != ST_OK)
                    st = err;
                else if (!(ph == PH_OPTHEAD || (ph == PH_PAYLOAD && saw_pay)))
                    st = ST_MALFORMED;
                else if (code_cls == CC_REQ && code_det == 5'd0)
                    st = (m_type == MT_NON || tok_len != 4'd0 || saw_opt || saw_pay) ?
                         ST_MALFORMED : ST_OK;
                else
                    st = (m_type == MT_RST) ? ST_MALFORMED : ST_OK;
            end

            r.data_out      = b;
            r.option_number = show ? last_opt_num : 16'd0;
            r.option_length = show ? len_acc : 17'd0;
            r.done_res      = fin;
            r.status        = st;
            r.msg_type      = m_type;
            r.token_length  = tok_len;
            r.msg_class     = code_cls;
            r.msg_detail    = code_det;
            r.message_id    = msg_id;
            labels_due.push_back(r);
            if (fin)
                clear_state();
        endfunction

        task report(string what, logic [31:0] got_v, logic [31:0] want_v);
            errors++;
            if (errors <= 40)
                $display("ERROR: result %0d, %s: got %0h, expected %0h",
                         checked, what, got_v, want_v);
        endtask

        task cmp(string what, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v)
                report(what, got_v, want_v);
        endtask

        task check_result(result_t got);
            result_t want;
            if (labels_due.size() == 0)
            begin
                report("result with no item pending", {24'd0, got.data_out}, 32'd0);
                return;
            end
            want = labels_due.pop_front();
            cmp("byte_class", 32'(got.byte_class), 32'(want.byte_class));
            cmp("data_out", 32'(got.data_out), 32'(want.data_out));
            cmp("option_number", 32'(got.option_number), 32'(want.option_number));
            cmp("option_length", 32'(got.option_length), 32'(want.option_length));
            cmp("done_res", 32'(got.done_res), 32'(want.done_res));
            cmp("status", 32'(got.status), 32'(want.status));
            cmp("msg_type", 32'(got.msg_type), 32'(want.msg_type));
            cmp("token_length", 32'(got.token_length), 32'(want.token_length));
            cmp("msg_class", 32'(got.msg_class), 32'(want.msg_class));
            cmp("msg_detail", 32'(got.msg_detail), 32'(want.msg_detail));
            cmp("message_id", 32'(got.message_id), 32'(want.message_id));
            checked++;
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data = 8'd0;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  byte_class;
    logic [7:0]  data_out;
    logic [15:0] option_number;
    logic [16:0] option_length;
    logic        done_res;
    logic [1:0]  status;
    logic [1:0]  msg_type;
    logic [3:0]  token_length;
    logic [2:0]  msg_class;
    logic [4:0]  msg_detail;
    logic [15:0] message_id;

    coap_label_scoreboard sb;
    logic [7:0]  dgram[$];
    result_t     got;
    int unsigned bytes_sent = 0;
    int unsigned cycles = 0;
    int unsigned stall_left = 0;
    logic        idle_on = 1'b0;

    coap_message_stream_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data          (data),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_class    (byte_class),
        .data_out      (data_out),
        .option_number (option_number),
        .option_length (option_length),
        .done_res      (done_res),
        .status        (status),
        .msg_type      (msg_type),
        .token_length  (token_length),
        .msg_class     (msg_class),
        .msg_detail    (msg_detail),
        .message_id    (message_id)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got = {byte_class, data_out, option_number, option_length, done_res, status,
                   msg_type, token_length, msg_class, msg_detail, message_id};
            sb.check_result(got);
        end
    end

    function automatic void put_random(int unsigned n);
        repeat (n) dgram.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_header(logic [1:0] ver, logic [1:0] typ, logic [3:0] tkl,
                                       logic [2:0] cc, logic [4:0] cd, logic [15:0] mid);
        dgram.push_back({ver, typ, tkl});
        dgram.push_back({cc, cd});
        dgram.push_back(mid[15:8]);
        dgram.push_back(mid[7:0]);
    endfunction

    function automatic logic [3:0] ext_nibble(int unsigned v);
        if (v < 13)
            return v[3:0];
        else if (v < 269)
            return NIB_EXT8;
        return NIB_EXT16;
    endfunction

    function automatic void put_ext(int unsigned v);
        int unsigned x;
        if (v >= 269)
        begin
            x = v - 269;
            dgram.push_back(x[15:8]);
            dgram.push_back(x[7:0]);
        end
        else if (v >= 13)
        begin
            x = v - 13;
            dgram.push_back(x[7:0]);
        end
    endfunction

    function automatic void put_option(int unsigned delta, int unsigned vlen, bit body);
        dgram.push_back({ext_nibble(delta), ext_nibble(vlen)});
        put_ext(delta);
        put_ext(vlen);
        if (body)
            put_random(vlen);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        data     <= b;
        last     <= fin;
        do
            @(posedge clk);
        while (!in_ready);
        sb.label_byte(b, fin);
        bytes_sent++;
    endtask

    task automatic send_dgram();
        foreach (dgram[i])
            send_byte(dgram[i], i == dgram.size() - 1);
        dgram.delete();
    endtask

    // mostly well-formed datagrams with random content; some noise, bad headers and cuts
    task automatic send_random_message();
        logic [1:0]  typ;
        logic [3:0]  tkl;
        logic [2:0]  cc;
        logic [4:0]  cd;
        int unsigned mode;
        int unsigned nopt;
        int unsigned opt_num;
        int unsigned delta;
        int unsigned vlen;
        int unsigned cut;
        mode = $urandom_range(0, 99);
        if (mode < 15)
            put_random($urandom_range(1, 12));
        else
        begin
            typ = 2'($urandom_range(0, 3));
            tkl = 4'($urandom_range(0, 8));
            case ($urandom_range(0, 3))
                0: cc = CC_REQ;
                1: cc = CC_OK;
                2: cc = CC_CLIENT_ERR;
                default: cc = CC_SERVER_ERR;
            endcase
            cd = 5'($urandom_range(0, 31));
            if (cc == CC_REQ && $urandom_range(0, 1) == 0)
                cd = 5'd0;
            if (mode < 25)
                put_header(COAP_VERSION, typ, 4'd0, CC_REQ, 5'd0,
                           16'($urandom_range(0, 65535)));
            else
            begin
                if (mode < 35)
                    put_header(2'($urandom_range(0, 3)), typ, 4'($urandom_range(0, 15)),
                               3'($urandom_range(0, 7)), cd, 16'($urandom_range(0, 65535)));
                else
                    put_header(COAP_VERSION, typ, tkl, cc, cd, 16'($urandom_range(0, 65535)));
                put_random({28'd0, tkl});
                nopt = $urandom_range(0, 4);
                opt_num = 0;
                repeat (nopt)
                begin
                    case ($urandom_range(0, 29))
                        0: delta = $urandom_range(269, 3000);
                        1, 2: delta = $urandom_range(13, 268);
                        3: delta = (opt_num < 65536) ? 65536 - opt_num + $urandom_range(0, 200)
                                                     : 0;
                        4: delta = (opt_num <= 65535) ? 65535 - opt_num : 0;
                        default: delta = $urandom_range(0, 12);
                    endcase
                    if (delta > 65804)
                        delta = 65804;
                    case ($urandom_range(0, 59))
                        0: vlen = $urandom_range(269, 300);
                        1, 2, 3, 4: vlen = $urandom_range(13, 40);
                        default: vlen = $urandom_range(0, 12);
                    endcase
                    if ($urandom_range(0, 39) == 0)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            dgram.push_back({NIB_RESERVED, 4'($urandom_range(0, 15))});
                        else
                            dgram.push_back({4'($urandom_range(0, 15)), NIB_RESERVED});
                    end
                    put_option(delta, vlen, 1'b1);
                    opt_num += delta;
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    dgram.push_back(PAYLOAD_MARK);
                    put_random($urandom_range(0, 8));
                end
            end
            if ($urandom_range(0, 6) == 0)
            begin
                cut = $urandom_range(1, dgram.size());
                while (dgram.size() > cut)
                    void'(dgram.pop_back());
            end
        end
        send_dgram();
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        idle_on <= 1'b1;
        @(posedge clk);

        // empty confirmable, largest message id
        put_header(COAP_VERSION, MT_CON, 4'd0, CC_REQ, 5'd0, 16'hFFFF);
        send_dgram();
        // header cut short
        dgram.push_back({COAP_VERSION, MT_CON, 4'd0});
        send_dgram();
        // wrong version, trailing item ignored
        put_header(2'd0, MT_RST, 4'hF, 3'd7, 5'h1F, 16'h0000);
        dgram.push_back(PAYLOAD_MARK);
        send_dgram();
        // largest option number and length, ends before the option value
        put_header(COAP_VERSION, MT_ACK, 4'd0, CC_OK, 5'd5, 16'h1234);
        put_option(65535, 65804, 1'b0);
        send_dgram();
        // reserved delta nibble
        put_header(COAP_VERSION, MT_NON, 4'd0, CC_REQ, 5'd1, 16'h00A5);
        dgram.push_back({NIB_RESERVED, 4'd0});
        dgram.push_back(8'h00);
        send_dgram();

        while (bytes_sent < ITEM_TARGET)
        begin
            idle_on <= (bytes_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
            send_random_message();
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
